@@ rtl/assert_macros.svh @@
// Assertion macros shared by the polygon area RTL.
// Each use expects clk and rst_n in scope; checks are off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define PAS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("polygon area check failed");

// Check that a condition holds in the cycle after a trigger.
`define PAS_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("polygon area check failed");

`endif

@@ rtl/pas_pkg.sv @@
// Types and constants for the polygon area block.
// No dependencies; imported by every module of the block.
package pas_pkg;

  localparam int REG_W     = 12;               // configuration register width
  localparam int PIX_W     = 24;               // pixel area width
  localparam int REAL_W    = 48;               // real area width
  localparam int SQ_W      = 2 * REG_W;        // squared length width
  localparam int NUM_W     = PIX_W + SQ_W;     // scaled numerator width
  localparam int DIV_STEPS = NUM_W;            // one quotient bit per step
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REAL_LEN  = 1'b0,
    CFG_PIXEL_LEN = 1'b1
  } pas_cfg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQR,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } pas_bk_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pas_q_stat_t;

endpackage

@@ rtl/pas_front.sv @@
// Front end: accepts vertices, forms cross products and keeps the shoelace sum.
// Pushes one pixel area per closed polygon into the queue. Uses pas_pkg.
module pas_front
  import pas_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int SUM_BITS   = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  vtx_valid,
  output logic                  vtx_ready,
  input  logic [COORD_BITS-1:0] vtx_x,
  input  logic [COORD_BITS-1:0] vtx_y,
  input  logic                  vtx_last,
  input  pas_q_stat_t           q_stat,
  output logic                  q_push,
  output logic [PIX_W-1:0]      q_data
);

  `include "assert_macros.svh"

  localparam int PROD_W = 2 * COORD_BITS;
  localparam int DIFF_W = PROD_W + 1;
  localparam int ADD_W  = ((SUM_BITS > DIFF_W) ? SUM_BITS : DIFF_W) + 1;

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0] a,
    input logic signed [DIFF_W-1:0]   b
  );
    logic signed [ADD_W-1:0] t;
    logic                    hi_ovf;
    logic                    lo_ovf;
    t      = ADD_W'(a) + ADD_W'(b);
    hi_ovf = !t[ADD_W-1] && (|t[ADD_W-2:SUM_BITS-1]);
    lo_ovf = t[ADD_W-1] && !(&t[ADD_W-2:SUM_BITS-1]);
    if (hi_ovf) begin
      sat_add = {1'b0, {(SUM_BITS-1){1'b1}}};
    end else if (lo_ovf) begin
      sat_add = {1'b1, {(SUM_BITS-1){1'b0}}};
    end else begin
      sat_add = t[SUM_BITS-1:0];
    end
  endfunction

  // polygon tracking
  logic [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [1:0]            seen_r, seen_nxt;
  logic                  vtx_acc;
  logic                  stall;

  // stage A: products
  logic              a_vld_r, a_add_r, a_last_r, a_short_r;
  logic [PROD_W-1:0] a_p1_r, a_p2_r, a_p3_r, a_p4_r;

  // stage B: running sum
  logic signed [SUM_BITS-1:0] sum_r;
  logic signed [DIFF_W-1:0]   b_d1, b_d2;
  logic signed [SUM_BITS-1:0] b_s1;

  // stage C: closing term and magnitude
  logic                       c_vld_r, c_short_r;
  logic signed [SUM_BITS-1:0] c_sum_r;
  logic signed [DIFF_W-1:0]   c_d2_r;
  logic signed [SUM_BITS-1:0] c_s2;
  logic [SUM_BITS-1:0]        c_mag;
  logic [SUM_BITS-2:0]        c_half;
  logic [PIX_W-1:0]           c_pix;

  assign stall     = c_vld_r && q_stat.full;
  assign vtx_ready = !stall;
  assign vtx_acc   = vtx_valid && vtx_ready;

  always_comb begin
    if (vtx_last) begin
      seen_nxt = 2'd0;
    end else if (seen_r == 2'd0) begin
      seen_nxt = 2'd1;
    end else begin
      seen_nxt = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else if (vtx_acc) begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vtx_acc) begin
      prev_x_r <= vtx_x;
      prev_y_r <= vtx_y;
      if (seen_r == 2'd0) begin
        first_x_r <= vtx_x;
        first_y_r <= vtx_y;
      end
    end
  end

  // Stage A: cross terms against the previous vertex and against the first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (!stall) begin
      a_vld_r <= vtx_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (vtx_acc) begin
      a_add_r   <= (seen_r != 2'd0);
      a_last_r  <= vtx_last;
      a_short_r <= vtx_last && (seen_r == 2'd0);
      a_p1_r    <= PROD_W'(prev_x_r) * PROD_W'(vtx_y);
      a_p2_r    <= PROD_W'(vtx_x) * PROD_W'(prev_y_r);
      a_p3_r    <= PROD_W'(vtx_x) * PROD_W'(first_y_r);
      a_p4_r    <= PROD_W'(first_x_r) * PROD_W'(vtx_y);
    end
  end

  // Stage B: accumulate, hand the closing sum to stage C on a last vertex
  assign b_d1 = $signed({1'b0, a_p1_r}) - $signed({1'b0, a_p2_r});
  assign b_d2 = $signed({1'b0, a_p3_r}) - $signed({1'b0, a_p4_r});
  assign b_s1 = a_add_r ? sat_add(sum_r, b_d1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      c_vld_r <= 1'b0;
    end else if (!stall) begin
      c_vld_r <= a_vld_r && a_last_r;
      if (a_vld_r) begin
        sum_r <= a_last_r ? '0 : b_s1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && a_vld_r && a_last_r) begin
      c_sum_r   <= b_s1;
      c_d2_r    <= b_d2;
      c_short_r <= a_short_r;
    end
  end

  // Stage C: close the polygon, take |sum|/2 and clamp
  assign c_s2   = sat_add(c_sum_r, c_d2_r);
  assign c_mag  = c_s2[SUM_BITS-1] ? SUM_BITS'(-c_s2) : SUM_BITS'(c_s2);
  assign c_half = c_mag[SUM_BITS-1:1];
  assign c_pix  = (|c_half[SUM_BITS-2:PIX_W]) ? {PIX_W{1'b1}} : c_half[PIX_W-1:0];

  assign q_push = c_vld_r && !q_stat.full;
  assign q_data = c_short_r ? '0 : c_pix;

  `PAS_ASSERT_NEXT(a_last_clears, vtx_acc && vtx_last, seen_r == 2'd0)
  `PAS_ASSERT(a_stall_only_on_close, !vtx_ready |-> c_vld_r)

endmodule

@@ rtl/pas_queue.sv @@
// Two-entry queue of pixel areas between the front and the back end.
// Uses pas_pkg for widths and the status struct.
module pas_queue
  import pas_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [PIX_W-1:0] push_data,
  input  logic             pop,
  output logic [PIX_W-1:0] pop_data,
  output pas_q_stat_t      stat
);

  `include "assert_macros.svh"

  logic [PIX_W-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `PAS_ASSERT(q_cnt_bound, cnt_r <= 2'd2)

endmodule

@@ rtl/pas_back.sv @@
// Back end: scales a pixel area by (real/pixel length) squared.
// Two multiply steps and a bit-serial restoring divider. Uses pas_pkg.
module pas_back
  import pas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pas_q_stat_t       q_stat,
  input  logic [PIX_W-1:0]  q_data,
  output logic              q_pop,
  input  logic [REG_W-1:0]  real_len,
  input  logic [REG_W-1:0]  pixel_len,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [PIX_W-1:0]  res_pix,
  output logic [REAL_W-1:0] res_real
);

  `include "assert_macros.svh"

  pas_bk_state_t state_r, state_nxt;

  logic [PIX_W-1:0]  pix_r;
  logic [SQ_W-1:0]   rl2_r, pl2_r;
  logic [NUM_W-1:0]  num_r;        // dividend, shifts out as the quotient shifts in
  logic [SQ_W-1:0]   rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [REG_W-1:0]  pl_eff;
  logic [SQ_W:0]     div_shift, div_diff;
  logic              div_ge;
  logic [SQ_W-1:0]   rem_nxt;
  logic              out_vld_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [REAL_W-1:0] out_real_r;
  logic              out_free;
  logic              out_load;
  logic              div_done;

  assign pl_eff    = (pixel_len == '0) ? REG_W'(1) : pixel_len;
  assign out_free  = !out_vld_r || res_ready;
  assign div_done  = (cnt_r == CNT_W'(DIV_STEPS - 1));

  assign div_shift = {rem_r, num_r[NUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, pl2_r});
  assign div_diff  = div_shift - {1'b0, pl2_r};
  assign rem_nxt   = div_ge ? div_diff[SQ_W-1:0] : div_shift[SQ_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!q_stat.empty) state_nxt = BK_SQR;
      BK_SQR:  state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_DIV;
      BK_DIV:  if (div_done) state_nxt = BK_OUT;
      BK_OUT:  if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE: q_pop    = !q_stat.empty;
      BK_OUT:  out_load = out_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_MUL) begin
        cnt_r <= '0;
      end else if (state_r == BK_DIV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (res_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: pix_r <= q_data;
      BK_SQR: begin
        rl2_r <= SQ_W'(real_len) * SQ_W'(real_len);
        pl2_r <= SQ_W'(pl_eff) * SQ_W'(pl_eff);
      end
      BK_MUL: begin
        num_r <= NUM_W'(pix_r) * NUM_W'(rl2_r);
        rem_r <= '0;
      end
      BK_DIV: begin
        rem_r <= rem_nxt;
        num_r <= {num_r[NUM_W-2:0], div_ge};
      end
      default: pix_r <= pix_r;
    endcase
    if (out_load) begin
      out_pix_r  <= pix_r;
      out_real_r <= num_r;
    end
  end

  assign res_valid = out_vld_r;
  assign res_pix   = out_pix_r;
  assign res_real  = out_real_r;

  `PAS_ASSERT(b_divisor_nonzero, (state_r == BK_DIV) |-> (pl2_r != '0))
  `PAS_ASSERT_NEXT(b_pop_starts_job, q_pop, state_r == BK_SQR)

endmodule

@@ rtl/polygon_area_scaled.sv @@
// Throughput: one vertex per cycle unless stalled; each closed polygon holds
// the back end for 2 multiply steps, 48 divide steps of the bit-serial divider and
// 2 moves, and up to two closed polygons wait in the queue before the input stalls.
// Reset (synchronous, rst_n low): polygon cleared, queue empty, both lengths 1.
module polygon_area_scaled
  import pas_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int SUM_BITS   = 48,
  localparam int IN_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // vertex_x, vertex_y, zero pad
  input  logic                    in_tlast,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [PIX_W+REAL_W-1:0] out_tdata,  // pixel_area, real_area
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]        cfg_data
);

  logic [REG_W-1:0]  real_len_r, pixel_len_r;
  pas_q_stat_t       q_stat;
  logic              q_push, q_pop;
  logic [PIX_W-1:0]  q_wdata, q_rdata;
  logic [PIX_W-1:0]  res_pix;
  logic [REAL_W-1:0] res_real;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_len_r  <= REG_W'(1);
      pixel_len_r <= REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (pas_cfg_idx_t'(cfg_index))
        CFG_REAL_LEN:  real_len_r  <= cfg_data;
        CFG_PIXEL_LEN: pixel_len_r <= cfg_data;
        default:       real_len_r  <= real_len_r;
      endcase
    end
  end

  pas_front #(
    .COORD_BITS (COORD_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .vtx_valid (in_tvalid),
    .vtx_ready (in_tready),
    .vtx_x     (in_tdata[COORD_BITS-1:0]),
    .vtx_y     (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .vtx_last  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  pas_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  pas_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .real_len  (real_len_r),
    .pixel_len (pixel_len_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_pix   (res_pix),
    .res_real  (res_real)
  );

  assign out_tdata = {res_real, res_pix};

endmodule
